@@ src/qsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsm_pkg
// Types and constants shared by the quadrature speed meter and its divider.
// ----------------------------------------------------------------------------
package qsm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int DIV_W           = 2 * CFG_W;
  localparam int SCALE_W         = 24;
  localparam int OUT_W           = 40;
  localparam int WIDE_W          = 64;

  // 60000 ms per minute times 256 for the Q8 fraction
  localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(15360000);

  localparam logic [WIDE_W-1:0] OUT_POS_LIMIT = (WIDE_W'(1) << (OUT_W - 1)) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] OUT_NEG_LIMIT = WIDE_W'(1) << (OUT_W - 1);

  localparam logic [CFG_W-1:0] CPR_RESET = CFG_W'(780);
  localparam logic [CFG_W-1:0] SPM_RESET = CFG_W'(10);

  typedef enum logic {
    CFG_COUNTS_PER_REV  = 1'b0,
    CFG_SAMPLE_PERIOD   = 1'b1
  } cfg_index_t;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    logic kind;
    logic level_a;
    logic level_b;
  } qsm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] speed_rpm_q8;
    logic                    count_saturated;
  } qsm_out_t;

endpackage

`default_nettype wire

@@ src/qsm_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsm_divider
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qsm_divider
  import qsm_pkg::*;
#(
  parameter int NUM_W = COUNT_WIDTH_DEF + SCALE_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [DIV_W-1:0] denom,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvsr;
  logic [DIV_W:0]   trial;
  logic             fits;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= CNT_W'(NUM_W);
      rem     <= '0;
      dvsr    <= denom;
      quot    <= numer;
    end else if (running) begin
      rem     <= fits ? DIV_W'(trial - {1'b0, dvsr}) : trial[DIV_W-1:0];
      quot    <= {quot[NUM_W-2:0], fits};
      cnt     <= cnt - CNT_W'(1);
      running <= (cnt != CNT_W'(1));
      done    <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ src/quadrature_speed_meter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_speed_meter
// x2 quadrature edge counter with a per-tick rpm readout in Q8 fixed point.
// ----------------------------------------------------------------------------
// An edge request (kind 0) counts up when the sampled A and B levels differ and
// down when they match; it gives no result. A tick request
// (kind 1) turns the count into count*15360000/(counts_per_rev*sample_period_ms),
// truncated toward zero and clamped to 40 bits signed, then clears the counter
// and its saturation flag. A tick stalls new requests from acceptance until the
// result is loaded: ST_MULT registers the product and divisor, ST_START starts
// the restoring divider, ST_DIVIDE waits on its done flag while it yields one
// quotient bit per cycle, and ST_FINISH clamps and loads the output once the
// output register is free. The output register lets the next edge or tick be
// accepted while a result still waits on out_stall. A counts_per_rev or
// sample_period_ms of zero acts as one.
// ----------------------------------------------------------------------------
module quadrature_speed_meter
  import qsm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire qsm_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output qsm_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // numerator holds magnitude times the rpm scale
  localparam int NUM_W = COUNT_WIDTH + SCALE_W;

  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_START,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] counts_per_rev;
  logic [CFG_W-1:0] sample_period_ms;

  // counter state
  logic signed [COUNT_WIDTH-1:0] pulse_count;
  logic                          saturated_flag;

  // tick snapshot
  logic [COUNT_WIDTH-1:0] mag;
  logic                   neg;
  logic                   sat_snap;
  logic [NUM_W-1:0]       product;
  logic [DIV_W-1:0]       divisor;

  // divider
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  logic             in_accept;
  logic             out_free;
  logic [CFG_W-1:0] cpr_eff;
  logic [CFG_W-1:0] spm_eff;
  logic [WIDE_W-1:0] quot_wide;
  logic [OUT_W-1:0]  speed_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == ST_START);

  // a zero register acts as one
  assign cpr_eff = (counts_per_rev == '0)   ? CFG_W'(1) : counts_per_rev;
  assign spm_eff = (sample_period_ms == '0) ? CFG_W'(1) : sample_period_ms;

  // clamp the magnitude to the 40-bit range and apply the sign
  always_comb begin
    quot_wide = WIDE_W'(div_quot);
    if (neg) begin
      if (quot_wide > OUT_NEG_LIMIT) begin
        speed_next = OUT_NEG_LIMIT[OUT_W-1:0];
      end else begin
        speed_next = OUT_W'(OUT_W'(0) - quot_wide[OUT_W-1:0]);
      end
    end else begin
      if (quot_wide > OUT_POS_LIMIT) begin
        speed_next = OUT_POS_LIMIT[OUT_W-1:0];
      end else begin
        speed_next = quot_wide[OUT_W-1:0];
      end
    end
  end

  qsm_divider #(
    .NUM_W (NUM_W)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (product),
    .denom (divisor),
    .done  (div_done),
    .quot  (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev   <= CPR_RESET;
      sample_period_ms <= SPM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COUNTS_PER_REV: counts_per_rev   <= cfg_data;
        CFG_SAMPLE_PERIOD:  sample_period_ms <= cfg_data;
        default:            ;
      endcase
    end
  end

  // sequencer, counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      pulse_count    <= '0;
      saturated_flag <= 1'b0;
    end else begin
      // drop the result once the consumer takes it; the finish step
      // reloads the register itself
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_data.kind == KIND_TICK) begin
              // snapshot the count as sign and magnitude, then clear it
              neg         <= pulse_count[COUNT_WIDTH-1];
              mag         <= pulse_count[COUNT_WIDTH-1] ?
                             COUNT_WIDTH'(-pulse_count) : COUNT_WIDTH'(pulse_count);
              sat_snap    <= saturated_flag;
              pulse_count <= '0;
              saturated_flag <= 1'b0;
              state       <= ST_MULT;
            end else if (in_data.level_a != in_data.level_b) begin
              // advance, hold at the upper limit
              if (pulse_count == COUNT_MAX) begin
                saturated_flag <= 1'b1;
              end else begin
                pulse_count <= pulse_count + COUNT_WIDTH'(1);
              end
            end else begin
              // retreat, hold at the lower limit
              if (pulse_count == COUNT_MIN) begin
                saturated_flag <= 1'b1;
              end else begin
                pulse_count <= pulse_count - COUNT_WIDTH'(1);
              end
            end
          end
        end
        ST_MULT: begin
          product <= NUM_W'(mag) * NUM_W'(RPM_SCALE);
          divisor <= DIV_W'(cpr_eff) * DIV_W'(spm_eff);
          state   <= ST_START;
        end
        ST_START: begin
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold here until the output register is free
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.speed_rpm_q8    <= speed_next;
            out_data.count_saturated <= sat_snap;
            state                    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A tick leaves a cleared counter behind.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.kind == KIND_TICK) |=> (pulse_count == '0 && !saturated_flag))
    else $error("counter not cleared after tick");

  // The divider finishes only while the sequencer waits on it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider done outside divide phase");

  // A result appears only from the finish step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result loaded outside finish step");

endmodule

`default_nettype wire
